[design/fmbd_pkg.sv]
`default_nettype none

package fmbd_pkg;

  localparam int unsigned DEF_CAPACITY   = 1024;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 11;

  localparam logic [REQ_W-1:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [REQ_W-1:0] OP_PUSH_MIDDLE = 3'd1;
  localparam logic [REQ_W-1:0] OP_PUSH_BACK   = 3'd2;
  localparam logic [REQ_W-1:0] OP_POP_FRONT   = 3'd3;
  localparam logic [REQ_W-1:0] OP_POP_MIDDLE  = 3'd4;
  localparam logic [REQ_W-1:0] OP_POP_BACK    = 3'd5;

endpackage

`default_nettype wire

[design/fmbd_ring.sv]
`default_nettype none

module fmbd_ring #(
  parameter int unsigned DEPTH      = 512,
  parameter int unsigned ADDR_WIDTH = 9,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_WIDTH-1:0] rd_addr,
  output logic      [DATA_WIDTH-1:0] rd_data,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_WIDTH-1:0] wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0] mem [0:DEPTH-1];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/front_middle_back_deque.sv]
`default_nettype none

// A deque of up to CAPACITY signed words with push and pop at the front, the
// middle and the back. The words are split over two ring buffers, each in a
// synchronous memory: the front half holds the first ceil(n/2) words and the
// back half the rest. In the accept cycle both rings are read; in the execute
// state, once the result register can take it, the result is formed, at most
// one word is written to each ring, and one word may move between the halves
// to keep them balanced. One request is in flight at a time, so no new request
// is taken until the current one is done; the result register lets the next
// request in while a result still waits. Every request gives one result beat
// with the occupancy after the request. A pop from an empty deque returns -1
// with was_empty set, and a push to a full deque is dropped with was_full set.
module front_middle_back_deque #(
  parameter int unsigned CAPACITY   = fmbd_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = fmbd_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [fmbd_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic signed [fmbd_pkg::VALUE_W-1:0] in_push_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [fmbd_pkg::VALUE_W-1:0] out_pop_value,
  output logic                                     out_was_empty,
  output logic                                     out_was_full,
  output logic             [fmbd_pkg::OCC_W-1:0]   out_occupancy
);

  import fmbd_pkg::*;

  localparam int unsigned HALF = (CAPACITY + 1) / 2;
  localparam int unsigned AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned HW   = $clog2(HALF + 1);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);

  localparam logic [AW-1:0] LAST_ADDR = AW'(HALF - 1);
  localparam logic [AW:0]   HALF_EXT  = (AW+1)'(HALF);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic [AW-1:0]         fh_r, fh_nxt, bh_r, bh_nxt;
  logic [HW-1:0]         f_r, f_nxt, b_r, b_nxt;
  logic [REQ_W-1:0]      op_r;
  logic [DATA_WIDTH-1:0] val_r;

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic                  out_empty_r, out_full_r;
  logic [OCC_W-1:0]      out_occ_r;

  logic                  accept, fire;
  logic [AW:0]           fsum, bsum;
  logic [AW-1:0]         fend, fback, fdec, finc;
  logic [AW-1:0]         bend, bback, bdec, binc;
  logic [CW-1:0]         n_cnt, n_nxt;
  logic                  n_odd, is_full, is_empty;

  logic [AW-1:0]         f_rd_addr, b_rd_addr;
  logic [DATA_WIDTH-1:0] rdf, rdb;
  logic                  wf_en, wb_en;
  logic [AW-1:0]         wf_addr, wb_addr;
  logic [DATA_WIDTH-1:0] wf_data, wb_data;

  logic [VALUE_W-1:0]    res_value;
  logic                  res_empty, res_full;

  assign fsum  = {1'b0, fh_r} + (AW+1)'(f_r);
  assign fend  = (fsum >= HALF_EXT) ? AW'(fsum - HALF_EXT) : fsum[AW-1:0];
  assign fback = (fend == '0) ? LAST_ADDR : fend - 1'b1;
  assign fdec  = (fh_r == '0) ? LAST_ADDR : fh_r - 1'b1;
  assign finc  = (fh_r == LAST_ADDR) ? '0 : fh_r + 1'b1;

  assign bsum  = {1'b0, bh_r} + (AW+1)'(b_r);
  assign bend  = (bsum >= HALF_EXT) ? AW'(bsum - HALF_EXT) : bsum[AW-1:0];
  assign bback = (bend == '0) ? LAST_ADDR : bend - 1'b1;
  assign bdec  = (bh_r == '0) ? LAST_ADDR : bh_r - 1'b1;
  assign binc  = (bh_r == LAST_ADDR) ? '0 : bh_r + 1'b1;

  assign n_cnt    = CW'(f_r) + CW'(b_r);
  assign n_odd    = n_cnt[0];
  assign is_full  = (n_cnt >= CAP_CNT);
  assign is_empty = (n_cnt == '0);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  assign f_rd_addr = (in_req_type == OP_POP_FRONT) ? fh_r : fback;
  assign b_rd_addr = (in_req_type == OP_POP_BACK) ? bback : bh_r;

  fmbd_ring #(
    .DEPTH      (HALF),
    .ADDR_WIDTH (AW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (f_rd_addr),
    .rd_data (rdf),
    .wr_en   (wf_en && fire),
    .wr_addr (wf_addr),
    .wr_data (wf_data)
  );

  fmbd_ring #(
    .DEPTH      (HALF),
    .ADDR_WIDTH (AW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (b_rd_addr),
    .rd_data (rdb),
    .wr_en   (wb_en && fire),
    .wr_addr (wb_addr),
    .wr_data (wb_data)
  );

  always_comb begin
    fh_nxt    = fh_r;
    bh_nxt    = bh_r;
    f_nxt     = f_r;
    b_nxt     = b_r;
    wf_en     = 1'b0;
    wb_en     = 1'b0;
    wf_addr   = fend;
    wb_addr   = bend;
    wf_data   = val_r;
    wb_data   = val_r;
    res_value = '0;
    res_empty = 1'b0;
    res_full  = 1'b0;
    case (op_r)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          res_full = 1'b1;
        end else begin
          wf_en   = 1'b1;
          wf_addr = fdec;
          fh_nxt  = fdec;
          if (!n_odd) begin
            f_nxt = f_r + 1'b1;
          end else begin
            wb_en   = 1'b1;
            wb_addr = bdec;
            wb_data = rdf;
            bh_nxt  = bdec;
            b_nxt   = b_r + 1'b1;
          end
        end
      end
      OP_PUSH_MIDDLE: begin
        if (is_full) begin
          res_full = 1'b1;
        end else if (!n_odd) begin
          wf_en = 1'b1;
          f_nxt = f_r + 1'b1;
        end else begin
          wf_en   = 1'b1;
          wf_addr = fback;
          wb_en   = 1'b1;
          wb_addr = bdec;
          wb_data = rdf;
          bh_nxt  = bdec;
          b_nxt   = b_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          res_full = 1'b1;
        end else if (n_odd) begin
          wb_en = 1'b1;
          b_nxt = b_r + 1'b1;
        end else if (b_r == '0) begin
          wf_en = 1'b1;
          f_nxt = f_r + 1'b1;
        end else begin
          wb_en   = 1'b1;
          wf_en   = 1'b1;
          wf_data = rdb;
          bh_nxt  = binc;
          f_nxt   = f_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          res_empty = 1'b1;
          res_value = '1;
        end else begin
          res_value = VALUE_W'($signed(rdf));
          fh_nxt    = finc;
          if (n_odd) begin
            f_nxt = f_r - 1'b1;
          end else begin
            wf_en   = 1'b1;
            wf_data = rdb;
            bh_nxt  = binc;
            b_nxt   = b_r - 1'b1;
          end
        end
      end
      OP_POP_MIDDLE: begin
        if (is_empty) begin
          res_empty = 1'b1;
          res_value = '1;
        end else begin
          res_value = VALUE_W'($signed(rdf));
          if (n_odd) begin
            f_nxt = f_r - 1'b1;
          end else begin
            wf_en   = 1'b1;
            wf_addr = fback;
            wf_data = rdb;
            bh_nxt  = binc;
            b_nxt   = b_r - 1'b1;
          end
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          res_empty = 1'b1;
          res_value = '1;
        end else if (n_odd && (b_r == '0)) begin
          res_value = VALUE_W'($signed(rdf));
          f_nxt     = f_r - 1'b1;
        end else if (n_odd) begin
          res_value = VALUE_W'($signed(rdb));
          wb_en     = 1'b1;
          wb_addr   = bdec;
          wb_data   = rdf;
          bh_nxt    = bdec;
          f_nxt     = f_r - 1'b1;
        end else begin
          res_value = VALUE_W'($signed(rdb));
          b_nxt     = b_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign n_nxt = CW'(f_nxt) + CW'(b_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fh_r        <= '0;
      bh_r        <= '0;
      f_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        fh_r        <= fh_nxt;
        bh_r        <= bh_nxt;
        f_r         <= f_nxt;
        b_r         <= b_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_req_type;
      val_r <= DATA_WIDTH'(in_push_value);
    end
    if (fire) begin
      out_value_r <= res_value;
      out_empty_r <= res_empty;
      out_full_r  <= res_full;
      out_occ_r   <= OCC_W'(n_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = $signed(out_value_r);
  assign out_was_empty = out_empty_r;
  assign out_was_full  = out_full_r;
  assign out_occupancy = out_occ_r;

`ifndef ASSERT_OFF
  a_halves_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (f_r == b_r) || (f_r == b_r + 1'b1))
    else $error("deque halves out of balance");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_cnt <= CAP_CNT)
    else $error("deque count above capacity");

  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("finished request gave no result beat");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> in_stall)
    else $error("request accepted while another is in flight");
`endif

endmodule

`default_nettype wire
